// ===== rtl/core/pps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

   // longest section is MAX_PATTERN_LEN-1 bytes
   localparam int MAX_PATTERN_LEN = 256;
   localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_PATTERN_LEN - 1);

   localparam logic [1:0] KIND_PATTERN = 2'd0;
   localparam logic [1:0] KIND_REPLACE = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   localparam logic [1:0] OP_MATCH      = 2'd0;
   localparam logic [1:0] OP_SUBSTITUTE = 2'd1;
   localparam logic [1:0] OP_TRANSLIT   = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_UNKNOWN_OP = 3'd1;
   localparam logic [2:0] ST_NO_DELIM   = 3'd2;
   localparam logic [2:0] ST_COUNT      = 3'd3;
   localparam logic [2:0] ST_MODIF      = 3'd4;
   localparam logic [2:0] ST_LONG       = 3'd5;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LT     = 8'h3c;
   localparam logic [7:0] CH_GT     = 8'h3e;
   localparam logic [7:0] CH_LBRACK = 8'h5b;
   localparam logic [7:0] CH_RBRACK = 8'h5d;
   localparam logic [7:0] CH_M      = 8'h6d;
   localparam logic [7:0] CH_S      = 8'h73;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_I      = 8'h69;
   localparam logic [7:0] CH_G      = 8'h67;
   localparam logic [7:0] CH_X      = 8'h78;

   typedef enum logic [2:0] {
      PH_OP,
      PH_TR,
      PH_DELIM,
      PH_BODY,
      PH_ERR
   } phase_type;

   // one result item; flags bit0 m, bit1 s, bit2 i, bit3 g, bit4 x
   typedef struct packed {
      logic [1:0] item_kind;
      logic [7:0] out_byte;
      logic [1:0] op_kind;
      logic [2:0] status;
      logic [4:0] flags;
      logic       last_of_pattern;
   } rsp_item_type;

   function automatic logic is_punct(input logic [7:0] b);
      return b inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]};
   endfunction

   // closing partner of a bracket, zero for anything else
   function automatic logic [7:0] close_of(input logic [7:0] b);
      logic [7:0] c;
      case (b)
         CH_LBRACE: c = CH_RBRACE;
         CH_LPAREN: c = CH_RPAREN;
         CH_LT:     c = CH_GT;
         CH_LBRACK: c = CH_RBRACK;
         default:   c = CH_NUL;
      endcase
      return c;
   endfunction

   // modifier flag mask, zero for an unknown modifier
   function automatic logic [4:0] modifier_mask(input logic [7:0] b);
      logic [4:0] m;
      case (b)
         CH_M:    m = 5'b00001;
         CH_S:    m = 5'b00010;
         CH_I:    m = 5'b00100;
         CH_G:    m = 5'b01000;
         CH_X:    m = 5'b10000;
         default: m = 5'b00000;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pps_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink   (input valid, input char_byte, output ready);
endinterface

interface pps_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] item_kind;
   logic [7:0] out_byte;
   logic [1:0] op_kind;
   logic [2:0] status;
   logic       flag_multiline;
   logic       flag_single_line;
   logic       flag_ignore_case;
   logic       flag_global;
   logic       flag_extended;
   logic       last_of_pattern;

   modport source (
      output valid, output item_kind, output out_byte, output op_kind, output status,
      output flag_multiline, output flag_single_line, output flag_ignore_case,
      output flag_global, output flag_extended, output last_of_pattern,
      input ready
   );
   modport sink (
      input valid, input item_kind, input out_byte, input op_kind, input status,
      input flag_multiline, input flag_single_line, input flag_ignore_case,
      input flag_global, input flag_extended, input last_of_pattern,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/pps_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pps_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [7:0]            char_byte,
   output logic                       res_valid,
   output pps_pkg::rsp_item_type      res_item
);
   import pps_pkg::*;

   typedef struct packed {
      logic       route;
      logic [1:0] kind;
      logic       modif;
      logic       count;
      logic       depth_inc;
      logic       depth_dec;
      logic       depth_zero;
   } act_type;

   phase_type        phase_ff, phase_in;
   logic [1:0]       op_ff, op_in;
   logic [7:0]       open_ff, open_in;
   logic [7:0]       close_ff, close_in;
   logic             paired_ff, paired_in;
   logic [1:0]       seen_ff, seen_in;
   logic [LEN_W-1:0] depth_ff, depth_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [4:0]       flags_ff, flags_in;
   logic [2:0]       err_ff, err_in;

   act_type          act;
   logic             slot_ok;
   logic             is_end;
   logic [4:0]       mask;
   logic [1:0]       expected;
   logic [2:0]       sum_status;

   assign is_end  = (char_byte == CH_NUL);
   assign slot_ok = (len_ff < LEN_LIMIT);
   assign mask    = modifier_mask(char_byte);

   // body byte decode
   always_comb begin
      act = '0;
      act.kind = KIND_PATTERN;
      if (op_ff == OP_MATCH && paired_ff) begin
         if (depth_ff == '0) begin
            act.modif = 1'b1;
         end else if (char_byte == open_ff) begin
            act.depth_inc = 1'b1;
            act.route     = 1'b1;
         end else if (char_byte == close_ff) begin
            if (depth_ff > LEN_W'(1)) begin
               act.depth_dec = 1'b1;
               act.route     = 1'b1;
            end else begin
               act.depth_zero = 1'b1;
               act.count      = 1'b1;
            end
         end else begin
            act.route = 1'b1;
         end
      end else if (op_ff == OP_MATCH) begin
         if (char_byte == open_ff) begin
            act.count = 1'b1;
         end else if (seen_ff == 2'd1) begin
            act.route = 1'b1;
         end else if (seen_ff == 2'd2) begin
            act.modif = 1'b1;
         end
      end else begin
         if (char_byte == open_ff) begin
            act.count = 1'b1;
         end else if (seen_ff == 2'd1) begin
            act.route = 1'b1;
         end else if (seen_ff == 2'd2) begin
            act.route = 1'b1;
            act.kind  = KIND_REPLACE;
         end else begin
            act.modif = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      op_in     = op_ff;
      open_in   = open_ff;
      close_in  = close_ff;
      paired_in = paired_ff;
      seen_in   = seen_ff;
      depth_in  = depth_ff;
      len_in    = len_ff;
      flags_in  = flags_ff;
      err_in    = err_ff;
      if (step) begin
         if (is_end) begin
            phase_in  = PH_OP;
            op_in     = OP_MATCH;
            open_in   = CH_NUL;
            close_in  = CH_NUL;
            paired_in = 1'b0;
            seen_in   = 2'd1;
            depth_in  = LEN_W'(1);
            len_in    = '0;
            flags_in  = '0;
            err_in    = ST_OK;
         end else begin
            case (phase_ff)
               PH_OP, PH_TR, PH_DELIM: begin
                  if (phase_ff == PH_OP && char_byte == CH_M) begin
                     op_in    = OP_MATCH;
                     phase_in = PH_DELIM;
                  end else if (phase_ff == PH_OP && char_byte == CH_S) begin
                     op_in    = OP_SUBSTITUTE;
                     phase_in = PH_DELIM;
                  end else if (phase_ff == PH_OP && char_byte == CH_T) begin
                     phase_in = PH_TR;
                  end else if (phase_ff == PH_TR && char_byte == CH_R) begin
                     op_in    = OP_TRANSLIT;
                     phase_in = PH_DELIM;
                  end else if (phase_ff != PH_TR && is_punct(char_byte)) begin
                     if (phase_ff == PH_OP) begin
                        op_in = OP_MATCH;
                     end
                     open_in   = char_byte;
                     close_in  = close_of(char_byte);
                     paired_in = (close_of(char_byte) != CH_NUL);
                     seen_in   = 2'd1;
                     depth_in  = LEN_W'(1);
                     len_in    = '0;
                     phase_in  = PH_BODY;
                  end else begin
                     err_in   = (phase_ff == PH_DELIM) ? ST_NO_DELIM : ST_UNKNOWN_OP;
                     phase_in = PH_ERR;
                  end
               end
               PH_BODY: begin
                  if (act.depth_inc) begin
                     depth_in = depth_ff + LEN_W'(1);
                  end else if (act.depth_dec) begin
                     depth_in = depth_ff - LEN_W'(1);
                  end else if (act.depth_zero) begin
                     depth_in = '0;
                  end
                  if (act.count) begin
                     if (seen_ff != 2'd0) begin
                        seen_in = seen_ff + 2'd1;
                     end
                     len_in = '0;
                  end
                  if (act.route || act.modif) begin
                     if (slot_ok) begin
                        len_in = len_ff + LEN_W'(1);
                        if (act.modif) begin
                           flags_in = flags_ff | mask;
                           if (mask == '0 && err_ff == ST_OK) begin
                              err_in = ST_MODIF;
                           end
                        end
                     end else begin
                        err_in   = ST_LONG;
                        phase_in = PH_ERR;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // summary status
   always_comb begin
      expected   = (op_ff == OP_MATCH) ? 2'd2 : 2'd3;
      sum_status = err_ff;
      if (err_ff == ST_OK && (phase_ff == PH_OP || phase_ff == PH_TR)) begin
         sum_status = ST_UNKNOWN_OP;
      end else if (err_ff == ST_OK && phase_ff == PH_DELIM) begin
         sum_status = ST_NO_DELIM;
      end
      if (sum_status != ST_UNKNOWN_OP && sum_status != ST_NO_DELIM &&
          sum_status != ST_LONG && seen_ff != expected) begin
         sum_status = ST_COUNT;
      end
   end

   // outputs
   always_comb begin
      res_valid = step && (is_end || (phase_ff == PH_BODY && act.route && slot_ok));
      res_item  = '0;
      res_item.op_kind = op_ff;
      if (is_end) begin
         res_item.item_kind       = KIND_SUMMARY;
         res_item.status          = sum_status;
         res_item.flags           = flags_ff;
         res_item.last_of_pattern = 1'b1;
      end else begin
         res_item.item_kind = act.kind;
         res_item.out_byte  = char_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OP;
         op_ff     <= OP_MATCH;
         open_ff   <= CH_NUL;
         close_ff  <= CH_NUL;
         paired_ff <= 1'b0;
         seen_ff   <= 2'd1;
         depth_ff  <= LEN_W'(1);
         len_ff    <= '0;
         flags_ff  <= '0;
         err_ff    <= ST_OK;
      end else begin
         phase_ff  <= phase_in;
         op_ff     <= op_in;
         open_ff   <= open_in;
         close_ff  <= close_in;
         paired_ff <= paired_in;
         seen_ff   <= seen_in;
         depth_ff  <= depth_in;
         len_ff    <= len_in;
         flags_ff  <= flags_in;
         err_ff    <= err_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pps_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pps_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire logic                  res_valid,
   input  wire pps_pkg::rsp_item_type res_item,
   input  wire logic                  out_ready,
   output logic                       out_valid,
   output pps_pkg::rsp_item_type      out_item,
   output logic                       slot_free
);
   import pps_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign slot_free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = res_valid;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res_valid) begin
         item_ff <= res_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ===== rtl/core/perl_pattern_splitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// splits a stream of perl-style pattern bytes (m//, s///, tr///, or a bare
// punctuation delimiter) into pattern and replacement bytes, one request byte
// at a time, with a zero byte ending each pattern and producing a summary item
// that carries the operation, the modifier flags m s i g x and a status code.
// delimiter and modifier bytes produce no result. one byte is taken per clock
// cycle for as long as results are drained; a byte goes through an input
// register and the combinational parse step into the result register, and the
// parse step waits while the result register is full and not draining. the
// parse state (phase, delimiter count, nesting depth, section length) is
// updated once per byte. sections longer than MAX_PATTERN_LEN-1 bytes are
// flagged with the too-long status and later bytes are dropped until the
// terminator.

module perl_pattern_splitter (
   input  wire logic    clock,
   input  wire logic    reset,
   pps_req_if.sink      req_chan,
   pps_rsp_if.source    rsp_chan
);
   import pps_pkg::*;

   // input register
   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;

   logic         parse_fire;
   logic         slot_free;
   logic         res_valid;
   rsp_item_type res_item;
   rsp_item_type out_item;

   // parse advances when the result slot is empty or draining
   assign parse_fire     = in_valid_ff && slot_free;
   assign req_chan.ready = !in_valid_ff || parse_fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (parse_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.char_byte;
      end
   end

   // per-byte parse state and routing
   pps_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (parse_fire),
      .char_byte (in_byte_ff),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   // result register
   pps_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (parse_fire),
      .res_valid (res_valid),
      .res_item  (res_item),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_item  (out_item),
      .slot_free (slot_free)
   );

   assign rsp_chan.item_kind        = out_item.item_kind;
   assign rsp_chan.out_byte         = out_item.out_byte;
   assign rsp_chan.op_kind          = out_item.op_kind;
   assign rsp_chan.status           = out_item.status;
   assign rsp_chan.flag_multiline   = out_item.flags[0];
   assign rsp_chan.flag_single_line = out_item.flags[1];
   assign rsp_chan.flag_ignore_case = out_item.flags[2];
   assign rsp_chan.flag_global      = out_item.flags[3];
   assign rsp_chan.flag_extended    = out_item.flags[4];
   assign rsp_chan.last_of_pattern  = out_item.last_of_pattern;

endmodule

`default_nettype wire

// ===== rtl/core/pps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pps_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] item_kind,
   input wire logic [2:0] status,
   input wire logic [4:0] flags,
   input wire logic       last_of_pattern
);
   import pps_pkg::*;

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled result dropped");

   // summary and last marker go together
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((item_kind == KIND_SUMMARY) == last_of_pattern))
      else $error("last marker does not match summary kind");

   // byte items carry no status or flags
   a_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && item_kind != KIND_SUMMARY |-> status == ST_OK && flags == 5'd0)
      else $error("byte item with status or flags");

   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> item_kind != 2'd3 && status <= ST_LONG)
      else $error("undefined kind or status code");

endmodule

bind perl_pattern_splitter pps_checker u_pps_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .item_kind       (rsp_chan.item_kind),
   .status          (rsp_chan.status),
   .flags           ({rsp_chan.flag_extended, rsp_chan.flag_global,
                      rsp_chan.flag_ignore_case, rsp_chan.flag_single_line,
                      rsp_chan.flag_multiline}),
   .last_of_pattern (rsp_chan.last_of_pattern)
);

`default_nettype wire

// ===== dv/tb_perl_pattern_splitter.sv =====
`timescale 1ns / 1ps

module tb_perl_pattern_splitter;
   import pps_pkg::*;

   // no request or result moving for this many cycles ends the run
   localparam int QUIET_LIMIT = 3000;
   // long receiver hold-off so the block backs up and stalls its input
   localparam int HOLD_CYCLES = 300;
   // drain time after the last expected result
   localparam int TAIL_CYCLES = 20;

   logic clock;
   logic reset;

   pps_req_if req_bus ();
   pps_rsp_if rsp_bus ();

   perl_pattern_splitter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // bytes waiting to be offered, and the split items they should produce
   logic [7:0]   pattern_bytes[$];
   rsp_item_type items_due[$];

   // idle percentages for each side, set per phase of the run
   int tx_idle_pct;
   int rx_idle_pct;
   int hold_asks;
   int hold_served;
   int hold_left;

   int n_queued;
   int n_requests;
   int n_results;
   int n_summaries;
   int n_fail;
   int quiet_cycles;
   int status_hits[8];

   rsp_item_type seen_item;

   // mirror of the splitter's parse state
   phase_type  parse_phase;
   logic [1:0] parse_op;
   logic [7:0] open_char;
   logic [7:0] close_char;
   logic       bracket_mode;
   logic [1:0] delim_count;   // wraps to zero once there are too many
   int         nest_level;
   int         section_len;
   logic [4:0] flag_bits;     // bit0 m, bit1 s, bit2 i, bit3 g, bit4 x
   logic [2:0] sticky_err;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   function automatic bit punct(input logic [7:0] b);
      return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
             (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
   endfunction

   // closing partner of an opening bracket, nul for anything else
   function automatic logic [7:0] bracket_mate(input logic [7:0] b);
      case (b)
         CH_LBRACE: return CH_RBRACE;
         CH_LPAREN: return CH_RPAREN;
         CH_LT:     return CH_GT;
         CH_LBRACK: return CH_RBRACK;
         default:   return CH_NUL;
      endcase
   endfunction

   function automatic void clear_parse();
      parse_phase  = PH_OP;
      parse_op     = OP_MATCH;
      open_char    = CH_NUL;
      close_char   = CH_NUL;
      bracket_mode = 1'b0;
      delim_count  = 2'd1;
      nest_level   = 1;
      section_len  = 0;
      flag_bits    = '0;
      sticky_err   = ST_OK;
   endfunction

   function automatic void push_item(input logic [1:0] kind, input logic [7:0] b,
                                     input logic [2:0] st, input logic [4:0] fl,
                                     input logic is_last);
      rsp_item_type it;
      it.item_kind       = kind;
      it.out_byte        = b;
      it.op_kind         = parse_op;
      it.status          = st;
      it.flags           = fl;
      it.last_of_pattern = is_last;
      items_due.push_back(it);
   endfunction

   // a section full up flags too-long and drops everything to the terminator
   function automatic bit grab_slot();
      if (section_len + 1 >= MAX_PATTERN_LEN) begin
         sticky_err  = ST_LONG;
         parse_phase = PH_ERR;
         return 1'b0;
      end
      section_len++;
      return 1'b1;
   endfunction

   function automatic void route_byte(input logic [1:0] kind, input logic [7:0] b);
      if (grab_slot())
         push_item(kind, b, ST_OK, 5'b0, 1'b0);
   endfunction

   function automatic void count_delim();
      if (delim_count != 2'd0)
         delim_count = delim_count + 2'd1;
      section_len = 0;
   endfunction

   function automatic void take_modifier(input logic [7:0] b);
      if (!grab_slot())
         return;
      case (b)
         CH_M:    flag_bits[0] = 1'b1;
         CH_S:    flag_bits[1] = 1'b1;
         CH_I:    flag_bits[2] = 1'b1;
         CH_G:    flag_bits[3] = 1'b1;
         CH_X:    flag_bits[4] = 1'b1;
         default: if (sticky_err == ST_OK) sticky_err = ST_MODIF;
      endcase
   endfunction

   function automatic void open_section(input logic [7:0] b);
      open_char    = b;
      close_char   = bracket_mate(b);
      bracket_mode = (close_char != CH_NUL);
      delim_count  = 2'd1;
      nest_level   = 1;
      section_len  = 0;
      parse_phase  = PH_BODY;
   endfunction

   function automatic void body_step(input logic [7:0] b);
      if (parse_op == OP_MATCH && bracket_mode) begin
         // nesting brackets only in match mode
         if (nest_level == 0) begin
            take_modifier(b);
         end else if (b == open_char) begin
            nest_level++;
            route_byte(KIND_PATTERN, b);
         end else if (b == close_char) begin
            if (nest_level > 1) begin
               nest_level--;
               route_byte(KIND_PATTERN, b);
            end else begin
               nest_level = 0;
               count_delim();
            end
         end else begin
            route_byte(KIND_PATTERN, b);
         end
      end else if (b == open_char) begin
         count_delim();
      end else if (parse_op == OP_MATCH) begin
         // after too many delimiters plain bytes are dropped
         if (delim_count == 2'd1)
            route_byte(KIND_PATTERN, b);
         else if (delim_count == 2'd2)
            take_modifier(b);
      end else if (delim_count == 2'd1) begin
         route_byte(KIND_PATTERN, b);
      end else if (delim_count == 2'd2) begin
         route_byte(KIND_REPLACE, b);
      end else begin
         take_modifier(b);
      end
   endfunction

   // one accepted request byte: update the mirror, queue what it produces
   function automatic void split_byte(input logic [7:0] b);
      logic [2:0] st;
      if (b == CH_NUL) begin
         st = sticky_err;
         if (st == ST_OK && (parse_phase == PH_OP || parse_phase == PH_TR))
            st = ST_UNKNOWN_OP;
         else if (st == ST_OK && parse_phase == PH_DELIM)
            st = ST_NO_DELIM;
         // wrong delimiter count wins over an unknown modifier
         if (st != ST_UNKNOWN_OP && st != ST_NO_DELIM && st != ST_LONG &&
             delim_count != ((parse_op == OP_MATCH) ? 2'd2 : 2'd3))
            st = ST_COUNT;
         push_item(KIND_SUMMARY, CH_NUL, st, flag_bits, 1'b1);
         clear_parse();
         return;
      end
      case (parse_phase)
         PH_OP: begin
            if (b == CH_M) begin
               parse_op    = OP_MATCH;
               parse_phase = PH_DELIM;
            end else if (b == CH_S) begin
               parse_op    = OP_SUBSTITUTE;
               parse_phase = PH_DELIM;
            end else if (b == CH_T) begin
               parse_phase = PH_TR;
            end else if (punct(b)) begin
               // bare punctuation means match and is the delimiter itself
               parse_op = OP_MATCH;
               open_section(b);
            end else begin
               sticky_err  = ST_UNKNOWN_OP;
               parse_phase = PH_ERR;
            end
         end
         PH_TR: begin
            if (b == CH_R) begin
               parse_op    = OP_TRANSLIT;
               parse_phase = PH_DELIM;
            end else begin
               sticky_err  = ST_UNKNOWN_OP;
               parse_phase = PH_ERR;
            end
         end
         PH_DELIM: begin
            if (punct(b)) begin
               open_section(b);
            end else begin
               sticky_err  = ST_NO_DELIM;
               parse_phase = PH_ERR;
            end
         end
         PH_BODY: body_step(b);
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // pattern generation
   // ------------------------------------------------------------------

   function automatic void queue_byte(input logic [7:0] b);
      pattern_bytes.push_back(b);
      n_queued++;
   endfunction

   function automatic bit is_flag(input logic [7:0] b);
      return b == CH_M || b == CH_S || b == CH_I || b == CH_G || b == CH_X;
   endfunction

   function automatic logic [7:0] rand_punct();
      logic [7:0] b;
      do b = 8'($urandom_range(33, 126)); while (!punct(b));
      return b;
   endfunction

   function automatic logic [7:0] rand_bracket();
      case ($urandom_range(3))
         0:       return CH_LBRACE;
         1:       return CH_LPAREN;
         2:       return CH_LT;
         default: return CH_LBRACK;
      endcase
   endfunction

   // any non-zero byte that is not a delimiter of this pattern
   function automatic logic [7:0] rand_body(input logic [7:0] dl, input logic [7:0] cl);
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == dl || b == cl);
      return b;
   endfunction

   function automatic logic [7:0] rand_flag();
      case ($urandom_range(4))
         0:       return CH_M;
         1:       return CH_S;
         2:       return CH_I;
         3:       return CH_G;
         default: return CH_X;
      endcase
   endfunction

   function automatic logic [7:0] rand_odd_modifier(input logic [7:0] dl,
                                                    input logic [7:0] cl);
      logic [7:0] b;
      do b = rand_body(dl, cl); while (is_flag(b));
      return b;
   endfunction

   // mostly well-formed m, s, tr or bare patterns with random content,
   // now and then a missing or extra delimiter or an odd modifier
   function automatic void add_pattern();
      int         pick;
      int         nest;
      bit         bare;
      bit         is_match;
      logic [7:0] dl;
      logic [7:0] cl;
      pick     = $urandom_range(99);
      bare     = 1'b0;
      is_match = 1'b1;
      if (pick < 30) begin
         queue_byte(CH_M);
      end else if (pick < 50) begin
         queue_byte(CH_S);
         is_match = 1'b0;
      end else if (pick < 68) begin
         queue_byte(CH_T);
         queue_byte(CH_R);
         is_match = 1'b0;
      end else begin
         bare = 1'b1;
      end
      if ($urandom_range(99) < 40)
         dl = rand_bracket();
      else
         dl = rand_punct();
      // a letter where the delimiter belongs
      if (!bare && $urandom_range(99) < 4)
         dl = 8'($urandom_range(97, 122));
      queue_byte(dl);
      cl = (is_match && bracket_mate(dl) != CH_NUL) ? bracket_mate(dl) : dl;
      nest = 0;
      repeat ($urandom_range(8)) begin
         pick = $urandom_range(99);
         if (cl != dl && pick < 12) begin
            queue_byte(dl);
            nest++;
         end else if (cl != dl && nest > 0 && pick < 24) begin
            queue_byte(cl);
            nest--;
         end else begin
            queue_byte(rand_body(dl, cl));
         end
      end
      repeat (nest) queue_byte(cl);
      if ($urandom_range(99) >= 5)
         queue_byte(cl);
      if (!is_match) begin
         repeat ($urandom_range(8)) queue_byte(rand_body(dl, cl));
         if ($urandom_range(99) >= 5)
            queue_byte(dl);
      end
      // one delimiter too many
      if ($urandom_range(99) < 5)
         queue_byte(cl);
      repeat ($urandom_range(3)) begin
         if ($urandom_range(99) < 8)
            queue_byte(rand_odd_modifier(dl, cl));
         else
            queue_byte(rand_flag());
      end
      queue_byte(CH_NUL);
   endfunction

   // truncated operations and plain garbage
   function automatic void add_noise();
      case ($urandom_range(3))
         0: queue_byte(CH_T);
         1: begin
            queue_byte(CH_T);
            queue_byte(CH_R);
         end
         2: queue_byte($urandom_range(1) ? CH_M : CH_S);
         default: repeat ($urandom_range(6)) queue_byte(8'($urandom));
      endcase
      queue_byte(CH_NUL);
   endfunction

   // section length limits: longest legal pattern, overlong replacement,
   // and overlong modifiers after an unknown modifier
   function automatic void add_long(input int which);
      queue_byte((which == 1) ? CH_S : CH_M);
      queue_byte("/");
      if (which == 0) begin
         repeat (MAX_PATTERN_LEN - 1) queue_byte(rand_body("/", "/"));
         queue_byte("/");
      end else begin
         queue_byte("a");
         queue_byte("/");
         if (which == 1) begin
            repeat (MAX_PATTERN_LEN) queue_byte(rand_body("/", "/"));
            queue_byte("/");
            queue_byte(CH_G);
         end else begin
            queue_byte("q");
            repeat (MAX_PATTERN_LEN - 1) queue_byte(CH_I);
         end
      end
      queue_byte(CH_NUL);
   endfunction

   // empty, lone t, t without r, bad operation byte, no delimiter,
   // nested bare brackets, substitute with an unknown modifier
   function automatic void add_directed();
      logic [7:0] seq [25] = '{
         CH_NUL,
         CH_T, CH_NUL,
         CH_T, CH_M, CH_NUL,
         8'hff, CH_NUL,
         CH_M, CH_NUL,
         CH_LBRACE, "a", CH_LBRACE, CH_RBRACE, CH_RBRACE, CH_G, CH_NUL,
         CH_S, "/", "a", "/", "b", "/", "q", CH_NUL
      };
      foreach (seq[i]) queue_byte(seq[i]);
   endfunction

   function automatic void fill_patterns(input int n);
      int start;
      start = n_queued;
      while (n_queued - start < n) begin
         if ($urandom_range(99) < 8)
            add_noise();
         else
            add_pattern();
      end
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         n_fail++;
      end
   endfunction

   function automatic void check_item(input rsp_item_type got);
      rsp_item_type want;
      n_results++;
      if (items_due.size() == 0) begin
         $error("result with nothing pending: kind %0d byte %0d", got.item_kind,
                got.out_byte);
         n_fail++;
         return;
      end
      want = items_due.pop_front();
      if (want.item_kind == KIND_SUMMARY) begin
         n_summaries++;
         status_hits[want.status]++;
      end
      check_field("item_kind", want.item_kind, got.item_kind);
      check_field("out_byte", want.out_byte, got.out_byte);
      check_field("op_kind", want.op_kind, got.op_kind);
      check_field("status", want.status, got.status);
      check_field("flag_multiline", want.flags[0], got.flags[0]);
      check_field("flag_single_line", want.flags[1], got.flags[1]);
      check_field("flag_ignore_case", want.flags[2], got.flags[2]);
      check_field("flag_global", want.flags[3], got.flags[3]);
      check_field("flag_extended", want.flags[4], got.flags[4]);
      check_field("last_of_pattern", want.last_of_pattern, got.last_of_pattern);
   endfunction

   // ------------------------------------------------------------------
   // request driver: predicts on each accepted byte, then offers the next
   // one from the backlog unless it idles this cycle
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.char_byte <= CH_NUL;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            split_byte(req_bus.char_byte);
            n_requests++;
         end
         // a byte on offer stays put until it is taken
         if (!req_bus.valid || req_bus.ready) begin
            if (pattern_bytes.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_bus.valid     <= 1'b1;
               req_bus.char_byte <= pattern_bytes.pop_front();
            end else begin
               req_bus.valid     <= 1'b0;
               req_bus.char_byte <= 8'($urandom);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result monitor: checks each accepted item, drives ready with random
   // stalls and the one long hold-off
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_item.item_kind       = rsp_bus.item_kind;
            seen_item.out_byte        = rsp_bus.out_byte;
            seen_item.op_kind         = rsp_bus.op_kind;
            seen_item.status          = rsp_bus.status;
            seen_item.flags           = {rsp_bus.flag_extended, rsp_bus.flag_global,
                                         rsp_bus.flag_ignore_case, rsp_bus.flag_single_line,
                                         rsp_bus.flag_multiline};
            seen_item.last_of_pattern = rsp_bus.last_of_pattern;
            check_item(seen_item);
         end
         if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // watchdog on cycles where neither side moves anything
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
         $display("tb_perl_pattern_splitter NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // run sequence
   // ------------------------------------------------------------------
   initial begin
      clear_parse();
      quiet_cycles      = 0;
      hold_asks         = 0;
      hold_served       = 0;
      tx_idle_pct       = 12;
      rx_idle_pct       = 88;
      req_bus.valid     = 1'b0;
      req_bus.char_byte = CH_NUL;
      rsp_bus.ready     = 1'b0;
      reset             = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // slow receiver: directed cases first, then random patterns
      add_directed();
      fill_patterns(110);
      while (pattern_bytes.size() > 0) @(posedge clock);

      // slow sender
      tx_idle_pct = 88;
      rx_idle_pct = 12;
      fill_patterns(100);
      while (pattern_bytes.size() > 0) @(posedge clock);

      // full rate, with length limits and one long receiver hold-off
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      add_long(0);
      add_long(1);
      add_long(2);
      fill_patterns(80);
      hold_asks++;

      while (pattern_bytes.size() > 0 || req_bus.valid) @(posedge clock);
      while (items_due.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d request bytes, %0d results, %0d pattern summaries, %0d mismatches",
               n_requests, n_results, n_summaries, n_fail);
      $display("summary status: ok %0d, bad op %0d, no delim %0d, count %0d, modifier %0d, long %0d",
               status_hits[ST_OK], status_hits[ST_UNKNOWN_OP], status_hits[ST_NO_DELIM],
               status_hits[ST_COUNT], status_hits[ST_MODIF], status_hits[ST_LONG]);
      if (n_fail == 0)
         $display("tb_perl_pattern_splitter OK");
      else
         $display("tb_perl_pattern_splitter NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pps_pkg.sv
rtl/core/pps_if.sv
rtl/core/pps_parser.sv
rtl/core/pps_out_reg.sv
rtl/core/perl_pattern_splitter.sv
rtl/core/pps_checker.sv
dv/tb_perl_pattern_splitter.sv
